@@ rtl/core/frd_pkg.sv @@
// ----------------------------------------------------------------------------
// frd_pkg: shared definitions for the frame receive deframer
// Field widths, phase and status codes, and the state and result records
// that pass between the top level and the step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package frd_pkg;

    // Field widths
    localparam int LEN_W   = 16;
    localparam int BYTE_W  = 8;
    localparam int STAT_W  = 3;
    localparam int PHASE_W = 3;

    // Receiver phases
    localparam logic [PHASE_W-1:0] PH_IDLE   = 3'd0;
    localparam logic [PHASE_W-1:0] PH_LEN_LO = 3'd1;
    localparam logic [PHASE_W-1:0] PH_LEN_HI = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DATA   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_CSUM   = 3'd4;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STAT_W-1:0] ST_DATA     = 3'd1;
    localparam logic [STAT_W-1:0] ST_OK       = 3'd2;
    localparam logic [STAT_W-1:0] ST_BAD_SUM  = 3'd3;
    localparam logic [STAT_W-1:0] ST_RX_ERR   = 3'd4;
    localparam logic [STAT_W-1:0] ST_BUSY     = 3'd5;
    localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd6;

    // Request codes
    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_ARM  = 1'b1;

    // Receiver state
    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [LEN_W-1:0]   length;
        logic [LEN_W-1:0]   count;
        logic [BYTE_W-1:0]  sum;
    } t_state;

    // One input item
    typedef struct packed {
        logic              req_type;
        logic [BYTE_W-1:0] rx_byte;
        logic              rx_error;
    } t_item;

    // One result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  byte_index;
        logic [LEN_W-1:0]  frame_length;
        logic [BYTE_W-1:0] calc_checksum;
    } t_result;

endpackage

`default_nettype wire

@@ rtl/core/frd_step.sv @@
// ----------------------------------------------------------------------------
// frd_step: per-byte state update of the deframer
// Takes the current receiver state and one item, gives the next state and
// the result item. Purely combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module frd_step (
    input  wire frd_pkg::t_state              i_state,
    input  wire frd_pkg::t_item               i_item,
    input  wire [frd_pkg::LEN_W-1:0]          i_max_len,
    output frd_pkg::t_state                   o_state,
    output frd_pkg::t_result                  o_result
);

    frd_pkg::t_state              n_state;
    logic [frd_pkg::STAT_W-1:0]   status;
    logic [frd_pkg::BYTE_W-1:0]   dbyte;
    logic [frd_pkg::LEN_W-1:0]    idx;
    logic [frd_pkg::LEN_W-1:0]    hdr_len;
    logic [frd_pkg::LEN_W-1:0]    next_count;

    // Full length once the high header byte lands
    assign hdr_len    = {i_item.rx_byte, i_state.length[frd_pkg::BYTE_W-1:0]};
    assign next_count = i_state.count + frd_pkg::LEN_W'(1);

    // Phase sequencing and result selection
    always_comb begin
        n_state = i_state;
        status  = frd_pkg::ST_NONE;
        dbyte   = '0;
        idx     = '0;
        if (i_item.req_type == frd_pkg::REQ_ARM) begin
            if (i_state.phase == frd_pkg::PH_IDLE) begin
                n_state.phase  = frd_pkg::PH_LEN_LO;
                n_state.length = '0;
                n_state.count  = '0;
                n_state.sum    = '0;
            end else begin
                status = frd_pkg::ST_BUSY;
            end
        end else begin
            unique case (i_state.phase)
                frd_pkg::PH_LEN_LO: begin
                    if (i_item.rx_error) begin
                        status        = frd_pkg::ST_RX_ERR;
                        n_state.phase = frd_pkg::PH_IDLE;
                    end else begin
                        n_state.length = frd_pkg::LEN_W'(i_item.rx_byte);
                        n_state.phase  = frd_pkg::PH_LEN_HI;
                    end
                end
                frd_pkg::PH_LEN_HI: begin
                    if (i_item.rx_error) begin
                        status        = frd_pkg::ST_RX_ERR;
                        n_state.phase = frd_pkg::PH_IDLE;
                    end else begin
                        n_state.length = hdr_len;
                        if (hdr_len > i_max_len) begin
                            status        = frd_pkg::ST_TOO_LONG;
                            n_state.phase = frd_pkg::PH_IDLE;
                        end else if (hdr_len == '0) begin
                            n_state.phase = frd_pkg::PH_CSUM;
                        end else begin
                            n_state.phase = frd_pkg::PH_DATA;
                        end
                    end
                end
                frd_pkg::PH_DATA: begin
                    idx = i_state.count;
                    if (i_item.rx_error) begin
                        status        = frd_pkg::ST_RX_ERR;
                        n_state.phase = frd_pkg::PH_IDLE;
                    end else begin
                        status        = frd_pkg::ST_DATA;
                        dbyte         = i_item.rx_byte;
                        n_state.sum   = i_state.sum + i_item.rx_byte;
                        n_state.count = next_count;
                        if (next_count == i_state.length) begin
                            n_state.phase = frd_pkg::PH_CSUM;
                        end
                    end
                end
                frd_pkg::PH_CSUM: begin
                    if (i_item.rx_error) begin
                        status = frd_pkg::ST_RX_ERR;
                        idx    = i_state.length;
                    end else if (i_item.rx_byte == i_state.sum) begin
                        status = frd_pkg::ST_OK;
                    end else begin
                        status = frd_pkg::ST_BAD_SUM;
                    end
                    n_state.phase = frd_pkg::PH_IDLE;
                end
                default: begin
                    // idle: a byte with no frame armed is dropped
                end
            endcase
        end
    end

    assign o_state                = n_state;
    assign o_result.status        = status;
    assign o_result.data_byte     = dbyte;
    assign o_result.byte_index    = idx;
    assign o_result.frame_length  = n_state.length;
    assign o_result.calc_checksum = n_state.sum;

endmodule

`default_nettype wire

@@ rtl/core/frame_receive_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// frame_receive_deframer_unit: length-prefixed frame receiver
// Arm, 16-bit length low byte first, data bytes, then a modulo-256 sum.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  input    | i_valid / o_ready    | i_req_type, i_rx_byte, i_rx_error
//  result   | o_valid / i_ready    | o_status, o_data_byte, o_byte_index,
//           |                      | o_frame_length, o_calc_checksum
//  config   | i_cfg_we             | i_cfg_wdata (max_frame_length)
//
//  One result per input transfer; one transfer per cycle sustained while the result side does not stall.
//  Path: input register, then step logic into the result register. Receiver
//  state updates as an item leaves the input register.
//  A stall on the result side holds the result register; o_ready drops
//  once the input register is also full.
//  Synchronous reset clears valids and receiver state, limit to 65535.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_receive_deframer_unit (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire [frd_pkg::LEN_W-1:0]    i_cfg_wdata,
    input  wire                         i_valid,
    output logic                        o_ready,
    input  wire                         i_req_type,
    input  wire [frd_pkg::BYTE_W-1:0]   i_rx_byte,
    input  wire                         i_rx_error,
    output logic                        o_valid,
    input  wire                         i_ready,
    output logic [frd_pkg::STAT_W-1:0]  o_status,
    output logic [frd_pkg::BYTE_W-1:0]  o_data_byte,
    output logic [frd_pkg::LEN_W-1:0]   o_byte_index,
    output logic [frd_pkg::LEN_W-1:0]   o_frame_length,
    output logic [frd_pkg::BYTE_W-1:0]  o_calc_checksum
);

    logic                     r_in_valid;
    frd_pkg::t_item           r_in_item;
    logic                     r_out_valid;
    frd_pkg::t_result         r_out;
    frd_pkg::t_state          r_state;
    logic [frd_pkg::LEN_W-1:0] r_max_len;

    frd_pkg::t_state          n_state;
    frd_pkg::t_result         n_out;
    logic                     out_free;
    logic                     step_go;
    logic                     in_take;

    // Handshake: each register advances when the one after it is free
    assign out_free = !r_out_valid || i_ready;
    assign step_go  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;
    assign in_take  = i_valid && o_ready;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= '1;
        end else if (i_cfg_we) begin
            r_max_len <= i_cfg_wdata;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.req_type <= i_req_type;
            r_in_item.rx_byte  <= i_rx_byte;
            r_in_item.rx_error <= i_rx_error;
        end
    end

    // Step logic
    frd_step u_step (
        .i_state  (r_state),
        .i_item   (r_in_item),
        .i_max_len(r_max_len),
        .o_state  (n_state),
        .o_result (n_out)
    );

    // Receiver state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase  <= frd_pkg::PH_IDLE;
            r_state.length <= '0;
            r_state.count  <= '0;
            r_state.sum    <= '0;
        end else if (step_go) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_go) begin
            r_out <= n_out;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out.status;
    assign o_data_byte     = r_out.data_byte;
    assign o_byte_index    = r_out.byte_index;
    assign o_frame_length  = r_out.frame_length;
    assign o_calc_checksum = r_out.calc_checksum;

endmodule

`default_nettype wire

@@ rtl/core/frd_checker.sv @@
// ----------------------------------------------------------------------------
// frd_checker: port-level checks for the frame receive deframer
// Watches the top-level ports only; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module frd_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         o_valid,
    input wire                         i_ready,
    input wire [frd_pkg::STAT_W-1:0]   o_status,
    input wire [frd_pkg::BYTE_W-1:0]   o_data_byte,
    input wire [frd_pkg::LEN_W-1:0]    o_byte_index,
    input wire [frd_pkg::LEN_W-1:0]    o_frame_length,
    input wire [frd_pkg::BYTE_W-1:0]   o_calc_checksum
);

    // A stalled result holds its status, index, length and checksum
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_byte_index)
            && $stable(o_frame_length) && $stable(o_calc_checksum))
        else $error("stalled result changed");

    // No result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Only defined status codes
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_status <= frd_pkg::ST_TOO_LONG)
        else $error("undefined status code");

    // Payload byte only with a data status
    a_dbyte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != frd_pkg::ST_DATA |-> o_data_byte == '0)
        else $error("data byte on a non-data result");

    // Index only reported for data and receive errors
    a_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != frd_pkg::ST_DATA && o_status != frd_pkg::ST_RX_ERR
            |-> o_byte_index == '0)
        else $error("byte index on a result that carries none");

endmodule

bind frame_receive_deframer_unit frd_checker u_frd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_data_byte    (o_data_byte),
    .o_byte_index   (o_byte_index),
    .o_frame_length (o_frame_length),
    .o_calc_checksum(o_calc_checksum)
);

`default_nettype wire

@@ tb/frame_receive_deframer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// frame_receive_deframer_unit_tb: self-checking bench for the frame receiver
// Drives arm requests and received bytes through the valid/ready input,
// predicts every result with a local copy of the receiver state, and checks
// each result transfer in order. A short directed table comes first, then
// random frames under several length limits, with random gaps on the input,
// random stalls on the output and one long output hold-off.
// ----------------------------------------------------------------------------
module frame_receive_deframer_unit_tb;
    import frd_pkg::*;

    localparam int DRAIN_LIMIT = 20000;
    localparam int HOLD_CYCLES = 400;
    localparam int MAX_SHOWN   = 10;
    localparam int NUM_DIR     = 29;
    localparam int NUM_PHASES  = 6;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_PATTERN} t_ready_mode;

    // one pending input transfer, optionally with a hand-written expectation
    typedef struct packed {
        t_item   item;
        logic    pinned;
        t_result result;
    } t_offer;

    typedef struct packed {
        t_row_kind         kind;
        logic              req;
        logic [BYTE_W-1:0] rx_b;
        logic              err;
        logic              pinned;
        t_result           result;
        logic [LEN_W-1:0]  limit;
    } t_dir_row;

    localparam logic             PIN       = 1'b1;
    localparam logic             FREE      = 1'b0;
    localparam logic [LEN_W-1:0] NO_CFG    = 16'h0000;
    localparam t_result          NO_RESULT = '0;

    // directed table: expected result typed in where it is obvious
    localparam t_dir_row [0:NUM_DIR-1] DIR_ROWS = {
        // byte while idle is ignored, even with an error
        {ROW_ITEM, REQ_BYTE, 8'hFF, 1'b1, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        // arm ignores its byte and error; second arm is rejected
        {ROW_ITEM, REQ_ARM,  8'hFF, 1'b1, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_BUSY,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        // three byte frame with a wrapping sum
        {ROW_ITEM, REQ_BYTE, 8'h03, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0003, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0003, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'hFF, 1'b0, FREE, NO_RESULT, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h01, 1'b0, FREE, NO_RESULT, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h80, 1'b0, FREE, NO_RESULT, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h80, 1'b0, PIN, ST_OK,       8'h00, 16'h0000, 16'h0003, 8'h80, NO_CFG},
        // largest length under the reset limit, busy arm, error on first data
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'hFF, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h00FF, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'hFF, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'hFFFF, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_BUSY,     8'h00, 16'h0000, 16'hFFFF, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h12, 1'b1, PIN, ST_RX_ERR,   8'h00, 16'h0000, 16'hFFFF, 8'h00, NO_CFG},
        // zero length frame, checksum compared against zero
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h01, 1'b0, PIN, ST_BAD_SUM,  8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        // error in the length header
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h02, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0002, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h5A, 1'b1, PIN, ST_RX_ERR,   8'h00, 16'h0000, 16'h0002, 8'h00, NO_CFG},
        // length one above the limit
        {ROW_CFG,  REQ_BYTE, 8'h00, 1'b0, FREE, NO_RESULT, 16'hFFFE},
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'hFF, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h00FF, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'hFF, 1'b0, PIN, ST_TOO_LONG, 8'h00, 16'h0000, 16'hFFFF, 8'h00, NO_CFG},
        // limit of zero
        {ROW_CFG,  REQ_BYTE, 8'h00, 1'b0, FREE, NO_RESULT, 16'h0000},
        {ROW_ITEM, REQ_ARM,  8'h00, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0000, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h01, 1'b0, PIN, ST_NONE,     8'h00, 16'h0000, 16'h0001, 8'h00, NO_CFG},
        {ROW_ITEM, REQ_BYTE, 8'h00, 1'b0, PIN, ST_TOO_LONG, 8'h00, 16'h0000, 16'h0001, 8'h00, NO_CFG}
    };

    // DUT ports
    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [LEN_W-1:0]    i_cfg_wdata = '0;
    logic                i_valid     = 1'b0;
    logic                o_ready;
    logic                i_req_type  = REQ_BYTE;
    logic [BYTE_W-1:0]   i_rx_byte   = '0;
    logic                i_rx_error  = 1'b0;
    logic                o_valid;
    logic                i_ready     = 1'b0;
    logic [STAT_W-1:0]   o_status;
    logic [BYTE_W-1:0]   o_data_byte;
    logic [LEN_W-1:0]    o_byte_index;
    logic [LEN_W-1:0]    o_frame_length;
    logic [BYTE_W-1:0]   o_calc_checksum;

    // predicted receiver state and length limit
    logic [PHASE_W-1:0]  rx_phase = PH_IDLE;
    logic [LEN_W-1:0]    rx_len   = '0;
    logic [LEN_W-1:0]    rx_count = '0;
    logic [BYTE_W-1:0]   rx_sum   = '0;
    logic [LEN_W-1:0]    rx_limit = 16'hFFFF;

    t_offer              link_queue [$];
    t_result             expected_reports [$];
    logic                offer_pinned = 1'b0;
    t_result             offer_result = '0;
    logic                offer_taken  = 1'b0;
    int                  burst_left   = 0;
    int                  gap_left     = 0;
    int                  fault_count  = 0;
    int                  items_queued = 0;

    logic                want_hold    = 1'b0;
    logic                hold_started = 1'b0;
    int                  hold_left    = 0;
    t_ready_mode         ready_mode   = RDY_ALWAYS;
    int                  mode_left    = 0;
    logic [15:0]         ready_bits   = '0;
    logic [3:0]          ready_pos    = '0;

    frame_receive_deframer_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_req_type      (i_req_type),
        .i_rx_byte       (i_rx_byte),
        .i_rx_error      (i_rx_error),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_data_byte     (o_data_byte),
        .o_byte_index    (o_byte_index),
        .o_frame_length  (o_frame_length),
        .o_calc_checksum (o_calc_checksum)
    );

    always #5 i_clk = ~i_clk;

    // one receiver step: advances the predicted state, returns the report
    function automatic t_result deframe_step(input t_item it);
        t_result r;
        r = '0;
        if (it.req_type == REQ_ARM) begin
            if (rx_phase == PH_IDLE) begin
                rx_phase = PH_LEN_LO;
                rx_len   = '0;
                rx_count = '0;
                rx_sum   = '0;
            end else begin
                r.status = ST_BUSY;
            end
        end else begin
            case (rx_phase)
                PH_LEN_LO: begin
                    if (it.rx_error) begin
                        r.status = ST_RX_ERR;
                        rx_phase = PH_IDLE;
                    end else begin
                        rx_len   = {8'h00, it.rx_byte};
                        rx_phase = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    if (it.rx_error) begin
                        r.status = ST_RX_ERR;
                        rx_phase = PH_IDLE;
                    end else begin
                        rx_len = {it.rx_byte, rx_len[7:0]};
                        if (rx_len > rx_limit) begin
                            r.status = ST_TOO_LONG;
                            rx_phase = PH_IDLE;
                        end else if (rx_len == '0) begin
                            rx_phase = PH_CSUM;
                        end else begin
                            rx_phase = PH_DATA;
                        end
                    end
                end
                PH_DATA: begin
                    r.byte_index = rx_count;
                    if (it.rx_error) begin
                        r.status = ST_RX_ERR;
                        rx_phase = PH_IDLE;
                    end else begin
                        rx_sum      = rx_sum + it.rx_byte;
                        r.status    = ST_DATA;
                        r.data_byte = it.rx_byte;
                        rx_count    = rx_count + 1'b1;
                        if (rx_count == rx_len) rx_phase = PH_CSUM;
                    end
                end
                PH_CSUM: begin
                    if (it.rx_error) begin
                        r.status     = ST_RX_ERR;
                        r.byte_index = rx_len;
                    end else begin
                        r.status = (it.rx_byte == rx_sum) ? ST_OK : ST_BAD_SUM;
                    end
                    rx_phase = PH_IDLE;
                end
                default: ;
            endcase
        end
        r.frame_length  = rx_len;
        r.calc_checksum = rx_sum;
        return r;
    endfunction

    task automatic queue_item(input logic req, input logic [BYTE_W-1:0] rx_b, input logic err,
                              input logic pinned, input t_result result);
        t_offer o;
        o.item.req_type = req;
        o.item.rx_byte  = rx_b;
        o.item.rx_error = err;
        o.pinned        = pinned;
        o.result        = result;
        link_queue.push_back(o);
    endtask

    // wait until every queued transfer went in and every report came out
    task automatic wait_drained();
        int spins;
        spins = 0;
        while ((link_queue.size() != 0 || i_valid || expected_reports.size() != 0)
               && spins < DRAIN_LIMIT) begin
            @(negedge i_clk);
            spins++;
        end
        // let the two-stage pipeline settle
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_length_limit(input logic [LEN_W-1:0] limit);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= limit;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        rx_limit     = limit;
    endtask

    // one random frame: mostly well formed, with errors, busy arms and noise
    task automatic queue_frame();
        int              pick;
        int              len;
        int              last_pos;
        int              err_pos;
        int              p;
        logic [LEN_W-1:0]  len16;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        // stray bytes while idle are dropped by the receiver
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 3))
                queue_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           FREE, NO_RESULT);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55)
            len = $urandom_range(0, 10);
        else if (pick < 70)
            len = $urandom_range(11, 40);
        else if (pick < 85)
            len = (rx_limit + $urandom_range(0, 2) + 65535) % 65536;
        else
            len = $urandom_range(0, 65535);
        len16    = len[LEN_W-1:0];
        last_pos = (len16 > rx_limit) ? 2 : len + 3;
        err_pos  = 0;
        if ($urandom_range(0, 7) == 0) err_pos = $urandom_range(1, last_pos);
        // long frames are always cut short by a receive error
        if (last_pos > 67 && (err_pos == 0 || err_pos > 11)) err_pos = $urandom_range(1, 11);

        queue_item(REQ_ARM, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                   FREE, NO_RESULT);
        items_queued++;
        sum = '0;
        for (p = 1; p <= last_pos && (err_pos == 0 || p <= err_pos); p++) begin
            if ($urandom_range(0, 24) == 0) begin
                queue_item(REQ_ARM, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                           FREE, NO_RESULT);
                items_queued++;
            end
            if (p == 1) begin
                b = len16[7:0];
            end else if (p == 2) begin
                b = len16[15:8];
            end else if (p == last_pos) begin
                b = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : sum;
            end else begin
                b   = 8'($urandom_range(0, 255));
                sum = sum + b;
            end
            queue_item(REQ_BYTE, b, p == err_pos, FREE, NO_RESULT);
            items_queued++;
        end
    endtask

    // input side: bursts of transfers separated by random gaps
    always @(negedge i_clk) begin : feed
        t_offer o;
        if (i_rst_n && !(i_valid && !offer_taken)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_valid <= 1'b0;
            end else if (link_queue.size() != 0) begin
                o = link_queue.pop_front();
                i_valid      <= 1'b1;
                i_req_type   <= o.item.req_type;
                i_rx_byte    <= o.item.rx_byte;
                i_rx_error   <= o.item.rx_error;
                offer_pinned <= o.pinned;
                offer_result <= o.result;
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end else begin
                    burst_left--;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result side: stall modes that change at random, one long hold-off
    always @(negedge i_clk) begin : drain
        if (want_hold && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode = t_ready_mode'($urandom_range(0, 3));
                mode_left  = $urandom_range(8, 80);
                ready_bits = 16'($urandom);
            end
            mode_left--;
            case (ready_mode)
                RDY_ALWAYS: i_ready <= 1'b1;
                RDY_HALF:   i_ready <= 1'($urandom_range(0, 1));
                RDY_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                default: begin
                    i_ready   <= ready_bits[ready_pos];
                    ready_pos  = ready_pos + 1'b1;
                end
            endcase
        end
    end

    // predict on every input transfer, check every result transfer
    always @(posedge i_clk) begin : watch
        t_item   seen;
        t_result want;
        t_result got;
        offer_taken = i_rst_n && i_valid && o_ready;
        if (offer_taken) begin
            seen.req_type = i_req_type;
            seen.rx_byte  = i_rx_byte;
            seen.rx_error = i_rx_error;
            want = deframe_step(seen);
            if (offer_pinned) want = offer_result;
            expected_reports.push_back(want);
        end
        if (i_rst_n && o_valid && i_ready) begin
            got.status        = o_status;
            got.data_byte     = o_data_byte;
            got.byte_index    = o_byte_index;
            got.frame_length  = o_frame_length;
            got.calc_checksum = o_calc_checksum;
            if (expected_reports.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_SHOWN)
                    $display("%0t: unexpected result st=%0d data=%h idx=%h len=%h sum=%h",
                             $time, got.status, got.data_byte, got.byte_index,
                             got.frame_length, got.calc_checksum);
            end else begin
                want = expected_reports.pop_front();
                if (got.status !== want.status || got.data_byte !== want.data_byte ||
                    got.byte_index !== want.byte_index ||
                    got.frame_length !== want.frame_length ||
                    got.calc_checksum !== want.calc_checksum) begin
                    fault_count++;
                    if (fault_count <= MAX_SHOWN)
                        $display("%0t: mismatch exp st=%0d data=%h idx=%h len=%h sum=%h",
                                 $time, want.status, want.data_byte, want.byte_index,
                                 want.frame_length, want.calc_checksum,
                                 "  got st=%0d data=%h idx=%h len=%h sum=%h",
                                 got.status, got.data_byte, got.byte_index,
                                 got.frame_length, got.calc_checksum);
                end
            end
        end
    end

    // stimulus sequence and verdict
    initial begin : run
        int r;
        int ph;
        int target;
        logic [LEN_W-1:0] limit;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table
        for (r = 0; r < NUM_DIR; r++) begin
            if (DIR_ROWS[r].kind == ROW_CFG)
                set_length_limit(DIR_ROWS[r].limit);
            else
                queue_item(DIR_ROWS[r].req, DIR_ROWS[r].rx_b, DIR_ROWS[r].err,
                           DIR_ROWS[r].pinned, DIR_ROWS[r].result);
        end

        // random frames under a sequence of length limits
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            case (ph)
                0:       limit = 16'hFFFF;
                1:       limit = 16'h0000;
                2:       limit = 16'h0001;
                3:       limit = 16'($urandom_range(2, 30));
                4:       limit = 16'd48;
                default: limit = 16'hFFFF;
            endcase
            set_length_limit(limit);
            target = items_queued + 142;
            while (items_queued < target) queue_frame();
            // output held off while the input keeps offering
            if (ph == 0) want_hold = 1'b1;
        end

        wait_drained();
        if (expected_reports.size() != 0) begin
            fault_count += expected_reports.size();
            $display("%0t: %0d results never arrived", $time, expected_reports.size());
        end
        if (fault_count == 0)
            $display("frame_receive_deframer_unit_tb: clean");
        else
            $display("frame_receive_deframer_unit_tb: errors");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #2_000_000;
        $display("%0t: timeout", $time);
        $display("frame_receive_deframer_unit_tb: errors");
        $finish;
    end

endmodule
